/* design/thc_pkg.sv */
`timescale 1ns / 1ps
// thc_pkg: types, register codes, constants and helpers for the
// temperature / humidity compensation pipeline; no dependencies

package thc_pkg;

  // pipeline depth, input register to output register
  localparam int unsigned NUM_STAGES = 11;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TEMP_TRIM_1  = 8'd0,
    CFG_TEMP_TRIM_2  = 8'd1,
    CFG_TEMP_TRIM_3  = 8'd2,
    CFG_HUM_TRIM_1   = 8'd3,
    CFG_HUM_TRIM_2   = 8'd4,
    CFG_HUM_TRIM_3   = 8'd5,
    CFG_HUM_TRIM_4_5 = 8'd6,
    CFG_HUM_TRIM_6   = 8'd7
  } cfg_reg_e;

  // arithmetic constants of the compensation formulas
  localparam logic signed [31:0] HUM_T_OFFSET   = 32'sd76800;
  localparam logic signed [31:0] HUM_P_ROUND    = 32'sd16384;
  localparam logic signed [31:0] HUM_Q_BIAS     = 32'sd2097152;
  localparam logic signed [31:0] HUM_Q2_BIAS    = 32'sd32768;
  localparam logic signed [31:0] HUM_Q_ROUND    = 32'sd8192;
  localparam logic signed [31:0] HUM_MAX        = 32'sd419430400;
  localparam logic signed [31:0] TEMP_ROUND     = 32'sd128;
  localparam logic signed [31:0] SAT24_MAX      = 32'sd8388607;
  localparam logic signed [31:0] SAT24_MIN      = -32'sd8388608;

  typedef struct packed {
    logic [19:0] raw_temperature;
    logic [15:0] raw_humidity;
  } thc_in_t;

  typedef struct packed {
    logic signed [23:0] temperature_centi;
    logic signed [23:0] fine_temperature;
    logic        [16:0] humidity_q10;
  } thc_out_t;

  // saturate a 32-bit signed word to signed 24 bits
  function automatic logic signed [23:0] sat24(input logic signed [31:0] x);
    logic signed [23:0] r;
    if (x < SAT24_MIN) begin
      r = 24'sh800000;
    end else if (x > SAT24_MAX) begin
      r = 24'sh7FFFFF;
    end else begin
      r = x[23:0];
    end
    return r;
  endfunction

endpackage

/* design/temp_humidity_compensation_top.sv */
`timescale 1ns / 1ps
// temp_humidity_compensation_top: pipelined integer temperature and humidity
// compensation with trim registers; depends on thc_pkg
//
//   channel | ports                                   | dir | carries
//   --------+-----------------------------------------+-----+--------------------------
//   in      | in_valid_i  in_ready_o  in_data_i       | in  | raw temperature, humidity
//   out     | out_valid_o out_ready_i out_data_o      | out | centi temp, fine temp, rh
//   cfg     | cfg_valid_i cfg_ready_o cfg_index_i/data| in  | trim register writes
//
// one transaction enters per cycle while the pipe advances; there are 11 register
// stages; eight stages each hold one of a chain of dependent 32-bit multiplies,
// the other three only add, shift, saturate or clamp
// the whole pipe advances on one enable; it holds only while the output
// register is full and not taken, so a stall loses and repeats nothing
// reset clears the stage valid bits and all trim registers to zero
// cfg writes are always taken and land in the next cycle

module temp_humidity_compensation_top
  import thc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  thc_in_t               in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output thc_out_t              out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // trim registers
  logic [15:0] t1_q, t2_q, t3_q, h2_q;
  logic [7:0]  h1_q, h3_q, h6_q;
  logic [23:0] h45_q;

  // trims widened to 32 bits, signed ones sign-extended
  logic signed [31:0] t1_s, t2_s, t3_s, h1_s, h2_s, h3_s, h4_s, h5_s, h6_s;

  // stage valid bits and the common advance enable
  logic [NUM_STAGES-1:0] vld_q;
  logic                  en;

  // stage payload registers
  logic signed [31:0] s1_ma_q, s1_dd_q;
  logic signed [31:0] s2_var1_q, s2_me3_q;
  logic signed [31:0] s3_tf_q;
  logic signed [31:0] s4_tf_q, s4_x_q, s4_tc5_q;
  logic signed [31:0] s5_h5x_q, s5_xh6_q, s5_xh3_q, s5_pb_q;
  logic signed [31:0] s6_p_q, s6_mq_q;
  logic signed [31:0] s7_p_q, s7_mqh2_q;
  logic signed [31:0] s8_v_q;
  logic signed [31:0] s9_v_q, s9_ss_q;
  logic signed [31:0] s10_v_q, s10_t_q;
  logic [15:0]        s1_rh_q, s2_rh_q, s3_rh_q, s4_rh_q;
  logic signed [23:0] tcs_q [5:10];
  logic signed [23:0] tfs_q [5:10];
  thc_out_t           out_q;

  // combinational results of each stage
  logic signed [31:0] rt32, a1, d1, ma1, dd1;
  logic signed [31:0] var1_2, e2, me3_2;
  logic signed [31:0] tf3;
  logic signed [31:0] x4, tc5_4;
  logic signed [31:0] h5x5, xh6_5, xh3_5, pb5, rh5;
  logic signed [31:0] p6, q1_6, q2_6, mq6;
  logic signed [31:0] q7, mqh2_7;
  logic signed [31:0] qq8, v8;
  logic signed [31:0] s9, ss9;
  logic signed [31:0] t10;
  logic signed [31:0] vc11, vk11;

  assign t1_s = {16'b0, t1_q};
  assign t2_s = {{16{t2_q[15]}}, t2_q};
  assign t3_s = {{16{t3_q[15]}}, t3_q};
  assign h1_s = {24'b0, h1_q};
  assign h2_s = {{16{h2_q[15]}}, h2_q};
  assign h3_s = {24'b0, h3_q};
  assign h4_s = {{20{h45_q[23]}}, h45_q[23:12]};
  assign h5_s = {{20{h45_q[11]}}, h45_q[11:0]};
  assign h6_s = {{24{h6_q[7]}}, h6_q};

  // pipe moves unless the output register holds an untaken result
  assign en          = !vld_q[NUM_STAGES-1] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[NUM_STAGES-1];
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

  // trim register writes, out-of-range indexes dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t1_q  <= '0;
      t2_q  <= '0;
      t3_q  <= '0;
      h1_q  <= '0;
      h2_q  <= '0;
      h3_q  <= '0;
      h45_q <= '0;
      h6_q  <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_TEMP_TRIM_1:  t1_q  <= cfg_data_i[15:0];
        CFG_TEMP_TRIM_2:  t2_q  <= cfg_data_i[15:0];
        CFG_TEMP_TRIM_3:  t3_q  <= cfg_data_i[15:0];
        CFG_HUM_TRIM_1:   h1_q  <= cfg_data_i[7:0];
        CFG_HUM_TRIM_2:   h2_q  <= cfg_data_i[15:0];
        CFG_HUM_TRIM_3:   h3_q  <= cfg_data_i[7:0];
        CFG_HUM_TRIM_4_5: h45_q <= cfg_data_i;
        CFG_HUM_TRIM_6:   h6_q  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // stage arithmetic, every product and sum wraps at 32 bits
  always_comb begin
    // stage 1: offset terms and the two first products
    rt32  = {12'b0, in_data_i.raw_temperature};
    a1    = (rt32 >>> 3) - (t1_s <<< 1);
    d1    = (rt32 >>> 4) - t1_s;
    ma1   = a1 * t2_s;
    dd1   = d1 * d1;
    // stage 2: linear term, quadratic term times t3
    var1_2 = s1_ma_q >>> 11;
    e2     = s1_dd_q >>> 12;
    me3_2  = e2 * t3_s;
    // stage 3: fine temperature
    tf3    = s2_var1_q + (s2_me3_q >>> 14);
    // stage 4: humidity temperature offset, tf * 5 + 128 by shift-add
    x4     = s3_tf_q - HUM_T_OFFSET;
    tc5_4  = (s3_tf_q <<< 2) + s3_tf_q + TEMP_ROUND;
    // stage 5: three products on x, humidity base term
    h5x5   = h5_s * s4_x_q;
    xh6_5  = s4_x_q * h6_s;
    xh3_5  = s4_x_q * h3_s;
    rh5    = {16'b0, s4_rh_q};
    pb5    = (rh5 <<< 14) - (h4_s <<< 20) + HUM_P_ROUND;
    // stage 6: humidity offset term, q1 * q2
    p6     = (s5_pb_q - s5_h5x_q) >>> 15;
    q1_6   = s5_xh6_q >>> 10;
    q2_6   = (s5_xh3_q >>> 11) + HUM_Q2_BIAS;
    mq6    = q1_6 * q2_6;
    // stage 7: gain factor times h2
    q7     = (s6_mq_q >>> 10) + HUM_Q_BIAS;
    mqh2_7 = q7 * h2_s;
    // stage 8: uncorrected humidity
    qq8    = (s7_mqh2_q + HUM_Q_ROUND) >>> 14;
    v8     = s7_p_q * qq8;
    // stage 9: square for the h1 correction
    s9     = s8_v_q >>> 15;
    ss9    = s9 * s9;
    // stage 10: square times h1
    t10    = (s9_ss_q >>> 7) * h1_s;
    // stage 11: correction and clamp to 0..HUM_MAX
    vc11   = s10_v_q - (s10_t_q >>> 4);
    if (vc11[31]) begin
      vk11 = '0;
    end else if (vc11 > HUM_MAX) begin
      vk11 = HUM_MAX;
    end else begin
      vk11 = vc11;
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NUM_STAGES-2:0], in_valid_i};
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_ma_q   <= ma1;
      s1_dd_q   <= dd1;
      s1_rh_q   <= in_data_i.raw_humidity;
      s2_var1_q <= var1_2;
      s2_me3_q  <= me3_2;
      s2_rh_q   <= s1_rh_q;
      s3_tf_q   <= tf3;
      s3_rh_q   <= s2_rh_q;
      s4_tf_q   <= s3_tf_q;
      s4_x_q    <= x4;
      s4_tc5_q  <= tc5_4;
      s4_rh_q   <= s3_rh_q;
      s5_h5x_q  <= h5x5;
      s5_xh6_q  <= xh6_5;
      s5_xh3_q  <= xh3_5;
      s5_pb_q   <= pb5;
      tcs_q[5]  <= sat24(s4_tc5_q >>> 8);
      tfs_q[5]  <= sat24(s4_tf_q);
      s6_p_q    <= p6;
      s6_mq_q   <= mq6;
      s7_p_q    <= s6_p_q;
      s7_mqh2_q <= mqh2_7;
      s8_v_q    <= v8;
      s9_v_q    <= s8_v_q;
      s9_ss_q   <= ss9;
      s10_v_q   <= s9_v_q;
      s10_t_q   <= t10;
      for (int k = 6; k <= 10; k++) begin
        tcs_q[k] <= tcs_q[k-1];
        tfs_q[k] <= tfs_q[k-1];
      end
      out_q.temperature_centi <= tcs_q[10];
      out_q.fine_temperature  <= tfs_q[10];
      out_q.humidity_q10      <= vk11[28:12];
    end
  end

`ifndef SYNTHESIS
  // a held pipe keeps every stage valid bit in place
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("stage valid bits moved during a stall");

  // the first stage only fills from an accepted transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(vld_q[0]) |-> $past(in_valid_i && in_ready_o))
    else $error("first stage filled without an input transaction");

  // clamped humidity never leaves its range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.humidity_q10 <= 17'd102400))
    else $error("humidity result above full scale");

  // a taken result with nothing behind it leaves the output empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !vld_q[NUM_STAGES-2] |=> !out_valid_o)
    else $error("output result repeated");
`endif

endmodule
